[src/page_pool_free_queue_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Page pool allocator assertion macros
// Shared property forms used by the RTL files of the page pool allocator.
// ----------------------------------------------------------------------------
`ifndef PAGE_POOL_FREE_QUEUE_ALLOCATOR_DEFINES_SVH
`define PAGE_POOL_FREE_QUEUE_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPFQ_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPFQ_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

[src/ppfq_pkg.sv]
// ----------------------------------------------------------------------------
// Page pool allocator package
// Widths, codes and shared types of the page pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfq_pkg;

    localparam int MAX_PAGES = 1024;
    localparam int PTR_W     = $clog2(MAX_PAGES);
    localparam int CNT_W     = PTR_W + 1;
    localparam int ADDR_W    = 48;
    localparam int PSIZE_W   = 31;
    localparam int THR_W     = 16;
    localparam int REM_W     = PSIZE_W;
    localparam int DCNT_W    = $clog2(ADDR_W + 1);
    localparam int MUL_A_W   = PSIZE_W;
    localparam int MUL_B_W   = THR_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 80;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PAGES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OK_THR     = 3'd4;

    localparam logic [1:0] MODE_GET     = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_SET     = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_BADADDR = 2'd2;
    localparam logic [1:0] STATUS_QFULL   = 2'd3;

    localparam logic [1:0] LVL_NORMAL = 2'd0;
    localparam logic [1:0] LVL_HIGH   = 2'd1;
    localparam logic [1:0] LVL_FULL   = 2'd2;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_FULL      = 2'd1;
    localparam logic [1:0] EV_HIGH      = 2'd2;
    localparam logic [1:0] EV_NORMAL    = 2'd3;

    localparam logic [ADDR_W-1:0]  RST_FIRST_ADDR = '0;
    localparam logic [PSIZE_W-1:0] RST_PAGE_SIZE  = 31'd4096;
    localparam logic [CNT_W-1:0]   RST_NUM_PAGES  = CNT_W'(MAX_PAGES);
    localparam logic [THR_W-1:0]   RST_HIGH_THR   = 16'd58982;
    localparam logic [THR_W-1:0]   RST_OK_THR     = 16'd32768;

    typedef struct packed {
        logic              done;
        logic              rem_zero;
        logic [ADDR_W-1:0] quotient;
    } div_res_t;

endpackage

`default_nettype wire

[src/ppfq_div.sv]
// ----------------------------------------------------------------------------
// Page pool address divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_pool_free_queue_allocator_defines.svh"

module ppfq_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [ppfq_pkg::ADDR_W-1:0]  dividend,
    input  wire logic [ppfq_pkg::PSIZE_W-1:0] divisor,
    output ppfq_pkg::div_res_t                res
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ppfq_pkg::DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [ppfq_pkg::ADDR_W-1:0]   dvd_reg, dvd_next;
    logic [ppfq_pkg::ADDR_W-1:0]   quo_reg, quo_next;
    logic [ppfq_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [ppfq_pkg::PSIZE_W-1:0]  dsr_reg, dsr_next;
    logic [ppfq_pkg::REM_W:0]      trial;
    logic [ppfq_pkg::REM_W:0]      diff;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[ppfq_pkg::ADDR_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ppfq_pkg::DCNT_W'(ppfq_pkg::ADDR_W);
            dvd_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[ppfq_pkg::ADDR_W-2:0], 1'b0};
            if (!diff[ppfq_pkg::REM_W])
            begin
                rem_next = diff[ppfq_pkg::REM_W-1:0];
                quo_next = {quo_reg[ppfq_pkg::ADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ppfq_pkg::REM_W-1:0];
                quo_next = {quo_reg[ppfq_pkg::ADDR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ppfq_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign res = {done_reg, (rem_reg == '0), quo_reg};

    `PPFQ_ASSERT_NEXT(a_div_done_pulse, done_reg, !done_reg, "divider done held")
    `PPFQ_ASSERT_NEXT(a_div_start_busy, start, busy_reg, "divider did not start")
    `PPFQ_ASSERT_NOW(a_div_cnt_live, busy_reg, cnt_reg != '0, "divider count ran out")

endmodule

`default_nettype wire

[src/page_pool_free_queue_allocator.sv]
// ----------------------------------------------------------------------------
// Page pool free queue allocator
// Hands out and takes back fixed-size pages through a FIFO of free indices.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ side: tuser carries the mode (get, release, set
// state), tdata the address and new page state. Each request gives exactly
// one response on the m_ side with status, page address and index, free page
// count and the occupancy level with any level transition.
// One request is handled at a time. A get does a queue memory read, an address
// multiply and two threshold multiplies on the shared multiplier.
// Release and set state run the address through a bit-serial divider.
// A new request is taken as soon as the previous one has been placed in the
// output register; if the receiver stalls and the output register is still
// full, the finished response waits in the block and s_tready stays low.
// Reset loads the default configuration and a full free queue of 1024 pages.
// A write of the page count register refills the queue with pages 0..n-1;
// entries never pushed since then read as their own position.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_pool_free_queue_allocator_defines.svh"

module page_pool_free_queue_allocator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // address[47:0], new_page_state[51:48], zero fill
    input  wire logic [ppfq_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode[1:0]
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], page_address[49:2], page_index[59:50], free_pages[70:60],
    // buffer_level[72:71], level_event[74:73], zero fill
    output logic [ppfq_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [ppfq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppfq_pkg::ADDR_W-1:0]       cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_POP   = 10'b0000000010,
        S_MUL   = 10'b0000000100,
        S_DIV   = 10'b0000001000,
        S_LVLHI = 10'b0000010000,
        S_LVLOK = 10'b0000100000,
        S_LVLEV = 10'b0001000000,
        S_OUT   = 10'b0010000000,
        S_START = 10'b0100000000,
        S_ADDR  = 10'b1000000000
    } state_t;

    localparam int PW = ppfq_pkg::PTR_W;
    localparam int CW = ppfq_pkg::CNT_W;
    localparam int AW = ppfq_pkg::ADDR_W;

    state_t state_reg;

    logic [AW-1:0]                    first_reg;
    logic [ppfq_pkg::PSIZE_W-1:0]     psize_reg;
    logic [CW-1:0]                    npages_reg;
    logic [ppfq_pkg::THR_W-1:0]       hithr_reg;
    logic [ppfq_pkg::THR_W-1:0]       okthr_reg;

    logic [PW-1:0]                    head_reg;
    logic [PW-1:0]                    tail_reg;
    logic [PW-1:0]                    tail0_reg;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    pushed_reg;
    logic [1:0]                       lvl_reg;

    logic [PW-1:0]                    fq_mem [ppfq_pkg::MAX_PAGES];
    logic [PW-1:0]                    rdata_reg;
    logic                             hit_reg;

    logic [1:0]                       mode_reg;
    logic [AW-1:0]                    addr_reg;
    logic [1:0]                       status_reg;
    logic [AW-1:0]                    paddr_reg;
    logic [PW-1:0]                    idx_reg;
    logic [1:0]                       event_reg;
    logic [ppfq_pkg::PROD_W-1:0]      prod_reg;
    logic [ppfq_pkg::PROD_W-1:0]      hip_reg;

    logic                             out_valid_reg;
    logic [ppfq_pkg::OUT_DATA_W-1:0]  out_data_reg;

    logic [ppfq_pkg::PSIZE_W-1:0]     psize_eff;
    logic [ppfq_pkg::MUL_A_W-1:0]     mul_a;
    logic [ppfq_pkg::MUL_B_W-1:0]     mul_b;
    logic [ppfq_pkg::PROD_W-1:0]      mul_p;
    logic [CW-1:0]                    used;
    logic [ppfq_pkg::PROD_W-1:0]      frac;
    logic [PW-1:0]                    head_dist;
    logic                             div_start;
    ppfq_pkg::div_res_t               div_res;
    logic                             div_ok;
    logic [CW-1:0]                    cfg_n;
    logic                             accept;
    logic                             out_free;

    assign psize_eff = (psize_reg == '0) ? ppfq_pkg::PSIZE_W'(1) : psize_reg;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign div_start = (state_reg == S_START);
    assign used      = npages_reg - count_reg;
    assign frac      = {{(ppfq_pkg::PROD_W - CW - 16){1'b0}}, used, 16'd0};
    assign head_dist = head_reg - tail0_reg;

    // Shared multiplier: page address in S_MUL, threshold products otherwise.
    always_comb
    begin
        if (state_reg == S_MUL)
        begin
            mul_a = psize_eff;
            mul_b = {{(ppfq_pkg::MUL_B_W - PW){1'b0}}, idx_reg};
        end
        else
        begin
            mul_a = {{(ppfq_pkg::MUL_A_W - CW){1'b0}}, npages_reg};
            mul_b = (state_reg == S_LVLOK) ? okthr_reg : hithr_reg;
        end
        mul_p = {{ppfq_pkg::MUL_B_W{1'b0}}, mul_a} * {{ppfq_pkg::MUL_A_W{1'b0}}, mul_b};
    end

    always_comb
    begin
        div_ok = div_res.rem_zero
              && (div_res.quotient[AW-1:CW] == '0)
              && (div_res.quotient[CW-1:0] < npages_reg);
        if (cfg_data[CW-1:0] == '0)
            cfg_n = CW'(1);
        else if (cfg_data[CW-1:0] > CW'(ppfq_pkg::MAX_PAGES))
            cfg_n = CW'(ppfq_pkg::MAX_PAGES);
        else
            cfg_n = cfg_data[CW-1:0];
    end

    ppfq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (addr_reg - first_reg),
        .divisor  (psize_eff),
        .res      (div_res)
    );

    // Free queue memory: one write port at the tail, one registered read at the head.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_res.done && div_ok
            && mode_reg == ppfq_pkg::MODE_RELEASE && count_reg < npages_reg)
        begin
            fq_mem[tail_reg] <= div_res.quotient[PW-1:0];
        end
        rdata_reg <= fq_mem[head_reg];
        hit_reg   <= ({1'b0, head_dist} < pushed_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= ppfq_pkg::RST_FIRST_ADDR;
            psize_reg     <= ppfq_pkg::RST_PAGE_SIZE;
            npages_reg    <= ppfq_pkg::RST_NUM_PAGES;
            hithr_reg     <= ppfq_pkg::RST_HIGH_THR;
            okthr_reg     <= ppfq_pkg::RST_OK_THR;
            head_reg      <= '0;
            tail_reg      <= ppfq_pkg::RST_NUM_PAGES[PW-1:0];
            tail0_reg     <= ppfq_pkg::RST_NUM_PAGES[PW-1:0];
            count_reg     <= ppfq_pkg::RST_NUM_PAGES;
            pushed_reg    <= '0;
            lvl_reg       <= ppfq_pkg::LVL_NORMAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    ppfq_pkg::REG_FIRST_ADDR: first_reg <= cfg_data;
                    ppfq_pkg::REG_PAGE_SIZE:  psize_reg <= cfg_data[ppfq_pkg::PSIZE_W-1:0];
                    ppfq_pkg::REG_NUM_PAGES:
                    begin
                        npages_reg <= cfg_n;
                        head_reg   <= '0;
                        tail_reg   <= cfg_n[PW-1:0];
                        tail0_reg  <= cfg_n[PW-1:0];
                        count_reg  <= cfg_n;
                        pushed_reg <= '0;
                        lvl_reg    <= ppfq_pkg::LVL_NORMAL;
                    end
                    ppfq_pkg::REG_HIGH_THR:   hithr_reg <= cfg_data[ppfq_pkg::THR_W-1:0];
                    ppfq_pkg::REG_OK_THR:     okthr_reg <= cfg_data[ppfq_pkg::THR_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg   <= s_tuser;
                        addr_reg   <= s_tdata[AW-1:0];
                        status_reg <= ppfq_pkg::STATUS_OK;
                        paddr_reg  <= '0;
                        idx_reg    <= '0;
                        event_reg  <= ppfq_pkg::EV_NONE;
                        case (s_tuser)
                            ppfq_pkg::MODE_GET:
                            begin
                                if (count_reg != '0)
                                    state_reg <= S_POP;
                                else
                                begin
                                    status_reg <= ppfq_pkg::STATUS_EMPTY;
                                    state_reg  <= S_LVLHI;
                                end
                            end
                            ppfq_pkg::MODE_RELEASE, ppfq_pkg::MODE_SET:
                                state_reg <= S_START;
                            default:
                                state_reg <= S_OUT;
                        endcase
                    end
                end
                S_POP:
                begin
                    idx_reg   <= hit_reg ? rdata_reg : head_reg;
                    head_reg  <= head_reg + 1'b1;
                    count_reg <= count_reg - 1'b1;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    paddr_reg <= first_reg + AW'(prod_reg);
                    state_reg <= S_LVLHI;
                end
                S_START:
                    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_res.done)
                    begin
                        if (!div_ok)
                        begin
                            status_reg <= ppfq_pkg::STATUS_BADADDR;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            idx_reg <= div_res.quotient[PW-1:0];
                            if (mode_reg == ppfq_pkg::MODE_SET)
                                state_reg <= S_OUT;
                            else
                            begin
                                if (count_reg >= npages_reg)
                                    status_reg <= ppfq_pkg::STATUS_QFULL;
                                else
                                begin
                                    tail_reg  <= tail_reg + 1'b1;
                                    count_reg <= count_reg + 1'b1;
                                    if (pushed_reg != CW'(ppfq_pkg::MAX_PAGES))
                                        pushed_reg <= pushed_reg + 1'b1;
                                end
                                state_reg <= S_LVLHI;
                            end
                        end
                    end
                end
                S_LVLHI:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_LVLOK;
                end
                S_LVLOK:
                begin
                    hip_reg   <= prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= S_LVLEV;
                end
                S_LVLEV:
                begin
                    // Full wins over high, high over the return to normal.
                    if (count_reg == '0 && lvl_reg != ppfq_pkg::LVL_FULL)
                    begin
                        lvl_reg   <= ppfq_pkg::LVL_FULL;
                        event_reg <= ppfq_pkg::EV_FULL;
                    end
                    else if (frac > hip_reg && lvl_reg == ppfq_pkg::LVL_NORMAL)
                    begin
                        lvl_reg   <= ppfq_pkg::LVL_HIGH;
                        event_reg <= ppfq_pkg::EV_HIGH;
                    end
                    else if (frac < prod_reg && lvl_reg != ppfq_pkg::LVL_NORMAL)
                    begin
                        lvl_reg   <= ppfq_pkg::LVL_NORMAL;
                        event_reg <= ppfq_pkg::EV_NORMAL;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            out_data_reg <= {5'd0, event_reg, lvl_reg, count_reg, idx_reg,
                             paddr_reg, status_reg};
        end
    end

    `PPFQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= npages_reg, "free count above pool size")
    `PPFQ_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE, "request taken but block idle")
    `PPFQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, $stable({m_tvalid, m_tdata}), "stall lost")

endmodule

`default_nettype wire

[tb/sv/page_pool_free_queue_allocator_tb.sv]
// ----------------------------------------------------------------------------
// Page pool allocator testbench
// Drives get, release, set-state and unused requests into the allocator under
// changing pool settings. A scoreboard keeps its own copy of the free queue,
// page states and occupancy level and checks every response field by field.
// ----------------------------------------------------------------------------
module page_pool_free_queue_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] PST_IDLE      = 4'd0;
    localparam logic [3:0] PST_ALLOCATED = 4'd1;
    localparam logic [3:0] PST_LAST      = 4'd8;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [2:0] REG_SPARE_LO  = 3'd5;
    localparam logic [2:0] REG_SPARE_HI  = 3'd7;

    typedef struct {
        logic [1:0]  status;
        logic [47:0] page_address;
        logic [9:0]  page_index;
        logic [10:0] free_pages;
        logic [1:0]  level;
        logic [1:0]  level_ev;
    } reply_t;

    class pool_tracker;
        logic [47:0] first_addr;
        logic [30:0] page_bytes;
        int unsigned pages;
        logic [15:0] high_thr;
        logic [15:0] ok_thr;
        logic [9:0]  free_q[ppfq_pkg::MAX_PAGES];
        logic [3:0]  pstate[ppfq_pkg::MAX_PAGES];
        int unsigned head;
        int unsigned tail;
        int unsigned count;
        logic [1:0]  level;
        reply_t      replies[$];
        int          errors;
        int          requests;
        int          transitions;

        function new();
            first_addr = ppfq_pkg::RST_FIRST_ADDR;
            page_bytes = ppfq_pkg::RST_PAGE_SIZE;
            pages      = ppfq_pkg::MAX_PAGES;
            high_thr   = ppfq_pkg::RST_HIGH_THR;
            ok_thr     = ppfq_pkg::RST_OK_THR;
            errors     = 0;
            requests   = 0;
            transitions = 0;
            refill();
        endfunction

        function void refill();
            for (int i = 0; i < ppfq_pkg::MAX_PAGES; i++)
            begin
                free_q[i] = (i < pages) ? 10'(i) : 10'd0;
                pstate[i] = PST_IDLE;
            end
            head  = 0;
            tail  = (pages >= ppfq_pkg::MAX_PAGES) ? 0 : pages;
            count = pages;
            level = ppfq_pkg::LVL_NORMAL;
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] v);
            case (idx)
                ppfq_pkg::REG_FIRST_ADDR: first_addr = v;
                ppfq_pkg::REG_PAGE_SIZE:  page_bytes = v[30:0];
                ppfq_pkg::REG_NUM_PAGES:
                begin
                    if (v[10:0] == 0)
                        pages = 1;
                    else if (v[10:0] > ppfq_pkg::MAX_PAGES)
                        pages = ppfq_pkg::MAX_PAGES;
                    else
                        pages = v[10:0];
                    refill();
                end
                ppfq_pkg::REG_HIGH_THR:   high_thr = v[15:0];
                ppfq_pkg::REG_OK_THR:     ok_thr = v[15:0];
                default: ;
            endcase
        endfunction

        function longint unsigned stride();
            return (page_bytes == 0) ? 64'd1 : 64'(page_bytes);
        endfunction

        function bit find_page(logic [47:0] a, output int unsigned idx);
            logic [47:0] off;
            longint unsigned ps;
            ps  = stride();
            off = a - first_addr;
            idx = 0;
            if (64'(off) % ps != 0)
                return 0;
            if (64'(off) / ps >= pages)
                return 0;
            idx = 32'(64'(off) / ps);
            return 1;
        endfunction

        // Hysteresis: full wins, then rising above high, then falling below ok.
        function logic [1:0] step_level();
            longint unsigned n;
            longint unsigned used;
            longint unsigned frac;
            n    = pages;
            used = n - count;
            frac = used * 65536;
            if (used == n && level != ppfq_pkg::LVL_FULL)
            begin
                level = ppfq_pkg::LVL_FULL;
                return ppfq_pkg::EV_FULL;
            end
            if (frac > 64'(high_thr) * n && level == ppfq_pkg::LVL_NORMAL)
            begin
                level = ppfq_pkg::LVL_HIGH;
                return ppfq_pkg::EV_HIGH;
            end
            if (frac < 64'(ok_thr) * n
                && (level == ppfq_pkg::LVL_FULL || level == ppfq_pkg::LVL_HIGH))
            begin
                level = ppfq_pkg::LVL_NORMAL;
                return ppfq_pkg::EV_NORMAL;
            end
            return ppfq_pkg::EV_NONE;
        endfunction

        function void note_request(logic [1:0] mode, logic [47:0] a, logic [3:0] ns);
            reply_t r;
            int unsigned idx;
            r.status = ppfq_pkg::STATUS_OK;
            r.page_address = '0;
            r.level_ev = ppfq_pkg::EV_NONE;
            idx = 0;
            requests++;
            case (mode)
                ppfq_pkg::MODE_GET:
                begin
                    if (count > 0)
                    begin
                        idx  = free_q[head];
                        head = (head + 1 >= ppfq_pkg::MAX_PAGES) ? 0 : head + 1;
                        count--;
                        pstate[idx] = PST_ALLOCATED;
                        r.page_address = 48'(64'(first_addr) + 64'(idx) * stride());
                    end
                    else
                        r.status = ppfq_pkg::STATUS_EMPTY;
                    r.level_ev = step_level();
                end
                ppfq_pkg::MODE_RELEASE:
                begin
                    if (!find_page(a, idx))
                        r.status = ppfq_pkg::STATUS_BADADDR;
                    else
                    begin
                        pstate[idx] = PST_IDLE;
                        if (count >= pages)
                            r.status = ppfq_pkg::STATUS_QFULL;
                        else
                        begin
                            free_q[tail] = 10'(idx);
                            tail = (tail + 1 >= ppfq_pkg::MAX_PAGES) ? 0 : tail + 1;
                            count++;
                        end
                        r.level_ev = step_level();
                    end
                end
                ppfq_pkg::MODE_SET:
                begin
                    if (!find_page(a, idx))
                        r.status = ppfq_pkg::STATUS_BADADDR;
                    else if (ns <= PST_LAST)
                        pstate[idx] = ns;
                end
                default: ;
            endcase
            r.page_index = 10'(idx);
            r.free_pages = 11'(count);
            r.level = level;
            if (r.level_ev != ppfq_pkg::EV_NONE)
                transitions++;
            replies.push_back(r);
        endfunction

        function void check_response(logic [ppfq_pkg::OUT_DATA_W-1:0] d);
            reply_t e;
            if (replies.size() == 0)
            begin
                $error("response with no request outstanding: %h", d);
                errors++;
                return;
            end
            e = replies.pop_front();
            if (d[1:0] !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, d[1:0]);
                errors++;
            end
            if (d[49:2] !== e.page_address)
            begin
                $error("page_address expected %h actual %h", e.page_address, d[49:2]);
                errors++;
            end
            if (d[59:50] !== e.page_index)
            begin
                $error("page_index expected %0d actual %0d", e.page_index, d[59:50]);
                errors++;
            end
            if (d[70:60] !== e.free_pages)
            begin
                $error("free_pages expected %0d actual %0d", e.free_pages, d[70:60]);
                errors++;
            end
            if (d[72:71] !== e.level)
            begin
                $error("buffer_level expected %0d actual %0d", e.level, d[72:71]);
                errors++;
            end
            if (d[74:73] !== e.level_ev)
            begin
                $error("level_event expected %0d actual %0d", e.level_ev, d[74:73]);
                errors++;
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [ppfq_pkg::IN_DATA_W-1:0]     s_tdata;
    logic [1:0]                         s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [ppfq_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic                               cfg_we;
    logic [ppfq_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [ppfq_pkg::ADDR_W-1:0]        cfg_data;

    pool_tracker sb;
    bit          calm;
    bit          rx_started;

    page_pool_free_queue_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #4ms;
        $display("simulation failed");
        $finish;
    end

    function int draw_gap();
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // The request valid stays high across back-to-back requests.
    task automatic send_request(logic [1:0] mode, logic [47:0] a, logic [3:0] ns);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'd0, ns, a};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(mode, a, ns);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.replies.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge clk);
    endtask

    function logic [47:0] page_addr(int unsigned idx);
        return 48'(64'(sb.first_addr) + 64'(idx) * sb.stride());
    endfunction

    function logic [47:0] pick_address();
        int k;
        longint unsigned ps;
        k  = $urandom_range(0, 9);
        ps = sb.stride();
        if (k <= 5)
            return page_addr($urandom_range(0, sb.pages - 1));
        if (k == 6)
            return page_addr(sb.pages + $urandom_range(0, 3));
        if (k == 7 && ps > 1)
            return page_addr($urandom_range(0, sb.pages - 1))
                + 48'($urandom_range(1, (ps > 64'd1000000) ? 1000000 : ps - 1));
        return 48'({$urandom, $urandom});
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_response(m_tdata);
    end

    // Receiver side: random stall before each response.
    initial
    begin
        int gap;
        wait (rx_started);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        logic [30:0] sizes[7];
        int          counts[12];
        int          burst;
        int          bias;
        logic [1:0]  mode;
        sizes  = '{31'd1, 31'd0, 31'd3, 31'd4096, 31'h7FFF_FFFF, 31'h4000_0000, 31'd0};
        counts = '{1, 2, 5, 1024, 0, 2047, 8, 3, 16, 7, 1024, 4};
        sb = new();
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ppfq_pkg::MODE_GET;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = ppfq_pkg::REG_FIRST_ADDR;
        cfg_data  = '0;
        calm      = 1'b0;
        rx_started = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        rx_started = 1'b1;

        // Default pool: double release, full queue, bad addresses, odd states.
        send_request(ppfq_pkg::MODE_GET, '0, 4'd0);
        send_request(ppfq_pkg::MODE_GET, '0, 4'd0);
        send_request(ppfq_pkg::MODE_RELEASE, 48'd4096, 4'd0);
        send_request(ppfq_pkg::MODE_RELEASE, 48'd4096, 4'd0);
        send_request(ppfq_pkg::MODE_RELEASE, 48'd0, 4'd0);
        send_request(ppfq_pkg::MODE_RELEASE, 48'd4097, 4'd0);
        send_request(ppfq_pkg::MODE_RELEASE, 48'd1024 * 48'd4096, 4'd0);
        send_request(ppfq_pkg::MODE_RELEASE, 48'hFFFF_FFFF_FFFF, 4'd0);
        send_request(ppfq_pkg::MODE_SET, 48'd8192, 4'd8);
        send_request(ppfq_pkg::MODE_SET, 48'd8192, 4'd9);
        send_request(ppfq_pkg::MODE_SET, 48'd8192, 4'd15);
        send_request(ppfq_pkg::MODE_SET, 48'd8191, 4'd2);
        send_request(MODE_UNUSED, 48'hFFFF_FFFF_FFFF, 4'hF);
        drain();

        // Single page with zero page size at the top of the address space.
        write_reg(ppfq_pkg::REG_FIRST_ADDR, 48'hFFFF_FFFF_FFFF);
        write_reg(ppfq_pkg::REG_PAGE_SIZE, 48'd0);
        write_reg(ppfq_pkg::REG_NUM_PAGES, 48'd1);
        send_request(ppfq_pkg::MODE_GET, '0, 4'd0);
        send_request(ppfq_pkg::MODE_GET, '0, 4'd0);
        send_request(ppfq_pkg::MODE_RELEASE, 48'hFFFF_FFFF_FFFF, 4'd0);
        send_request(ppfq_pkg::MODE_RELEASE, 48'd0, 4'd0);
        send_request(ppfq_pkg::MODE_SET, 48'hFFFF_FFFF_FFFF, 4'd3);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            if (p == 4)
            begin
                write_reg(REG_SPARE_LO, 48'({$urandom, $urandom}));
                write_reg(REG_SPARE_HI, 48'({$urandom, $urandom}));
            end
            write_reg(ppfq_pkg::REG_FIRST_ADDR, (p % 3 == 0) ? 48'd0 :
                (p % 3 == 1) ? 48'hFFFF_FFFF_FFFF : 48'({$urandom, $urandom}));
            write_reg(ppfq_pkg::REG_PAGE_SIZE, (p < 6) ? 48'(sizes[p]) :
                (p == 6) ? 48'({$urandom} & 32'h7FFF_FFFF) : 48'($urandom_range(1, 5000)));
            write_reg(ppfq_pkg::REG_HIGH_THR, (p == 0) ? 48'd0 : (p == 1) ? 48'd65535 :
                48'($urandom_range(0, 65535)));
            write_reg(ppfq_pkg::REG_OK_THR, (p == 0) ? 48'd0 : (p == 1) ? 48'd65535 :
                48'($urandom_range(0, 65535)));
            write_reg(ppfq_pkg::REG_NUM_PAGES, 48'(counts[p]));
            calm  = (p % 4 == 3);
            burst = (sb.pages == ppfq_pkg::MAX_PAGES) ? 66 : 76;
            for (int i = 0; i < burst; i++)
            begin
                // Fill the pool in the first half and drain it in the second.
                bias = (i < burst / 2) ? 80 : 20;
                if ($urandom_range(0, 99) < 3)
                    mode = MODE_UNUSED;
                else if ($urandom_range(0, 99) < bias)
                    mode = ppfq_pkg::MODE_GET;
                else if ($urandom_range(0, 3) == 0)
                    mode = ppfq_pkg::MODE_SET;
                else
                    mode = ppfq_pkg::MODE_RELEASE;
                send_request(mode, pick_address(), 4'($urandom_range(0, 15)));
            end
            drain();
        end

        if (sb.replies.size() != 0)
        begin
            $error("%0d responses never arrived", sb.replies.size());
            sb.errors++;
        end
        $display("Ran %0d requests over 14 pool settings, %0d level transitions checked.",
            sb.requests, sb.transitions);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
